>>> sv/bqc_pkg.sv
// Shared constants, types and coefficient tables of the band-pass biquad cascade.
// No dependencies; used by the interfaces, the top level and the checker.
package bqc_pkg;

  localparam int COEF_FRAC_BITS  = 28;
  localparam int STATE_FRAC_BITS = 24;
  localparam int OUT_FRAC_BITS   = 14;

  localparam int SAMPLE_W = 16;
  localparam int STATE_W  = 48;
  localparam int OUT_W    = 32;
  // Coefficient magnitude, wide enough for |-2.0| at the finest coefficient scale
  localparam int COEF_W   = 32;

  localparam int NUM_SEC = 2;
  localparam int NUM_POS = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]    result_t;
  typedef logic signed [STATE_W-1:0]  state_t;

  // b0, b1, b2, a1, a2 of each section, signed Q2.30
  localparam longint COEF_Q30 [NUM_SEC][NUM_POS] = '{
    '{64'sd39271931, 64'sd78543862, 64'sd39271931, -64'sd1525090081, 64'sd626377089},
    '{64'sd1073741824, -64'sd2147483648, 64'sd1073741824, -64'sd2057569497,
      64'sd988770576}
  };

  localparam int COEF_RSHIFT = 30 - COEF_FRAC_BITS;

  // Sequence position to coefficient slot: b0, b1, a1, b2, a2
  function automatic int coef_slot(int pos);
    int k;
    case (pos)
      2:       k = 3;
      3:       k = 2;
      default: k = pos;
    endcase
    return k;
  endfunction

  function automatic logic [COEF_W-1:0] coef_mag(int sec, int pos);
    longint q;
    longint m;
    q = COEF_Q30[sec][coef_slot(pos)];
    m = (q < 0) ? -q : q;
    if (COEF_RSHIFT > 0) begin
      m = (m + ((longint'(1) <<< COEF_RSHIFT) >>> 1)) >>> COEF_RSHIFT;
    end
    return m[COEF_W-1:0];
  endfunction

  function automatic logic coef_neg(int sec, int pos);
    return COEF_Q30[sec][coef_slot(pos)] < 0;
  endfunction

  localparam logic [COEF_W-1:0] COEF_MAG [NUM_SEC][NUM_POS] = '{
    '{coef_mag(0, 0), coef_mag(0, 1), coef_mag(0, 2), coef_mag(0, 3), coef_mag(0, 4)},
    '{coef_mag(1, 0), coef_mag(1, 1), coef_mag(1, 2), coef_mag(1, 3), coef_mag(1, 4)}
  };

  localparam logic COEF_NEG [NUM_SEC][NUM_POS] = '{
    '{coef_neg(0, 0), coef_neg(0, 1), coef_neg(0, 2), coef_neg(0, 3), coef_neg(0, 4)},
    '{coef_neg(1, 0), coef_neg(1, 1), coef_neg(1, 2), coef_neg(1, 3), coef_neg(1, 4)}
  };

endpackage

>>> sv/bqc_sample_if.sv
// Input channel of the biquad cascade: one raw sensor sample per item.
// Depends on bqc_pkg.
interface bqc_sample_if;
  logic              valid;
  logic              ready;
  bqc_pkg::sample_t  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

>>> sv/bqc_result_if.sv
// Output channel of the biquad cascade: one filtered sample per item.
// Depends on bqc_pkg.
interface bqc_result_if;
  logic              valid;
  logic              ready;
  bqc_pkg::result_t  filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

>>> sv/biquad_cascade_bandpass.sv
// Band-pass filter: low-pass biquad followed by high-pass biquad, transposed direct form II.
// Depends on bqc_pkg, bqc_sample_if and bqc_result_if.
//
// Usage:
//   sample_i carries one signed 16-bit sample per item (valid/ready, accepted when both
//   are high). result_o carries one signed 32-bit sample with 14 fractional bits per item.
//   sample_i.ready is high only while the sequencer is idle. An item runs through
//   10 coefficient products on the one shared 24x32 multiplier and accumulator,
//   each in the steps operand load, low half, high half and accumulate, and then
//   an output step that rescales and saturates the output. The next item is taken in
//   the cycle the result appears, so the sequencer takes no new item before it is
//   through with the last one.
//   The result sits in an output register; a new item is accepted while it waits. If the
//   receiver still stalls when the next result is ready, the sequencer holds in its
//   output step until the register frees.
//   Reset (rst_ni low, asynchronous) clears the four delay registers, the sequencer
//   and the output valid flag.
module biquad_cascade_bandpass (
  input  logic         clk_i,
  input  logic         rst_ni,
  bqc_sample_if.sink   sample_i,
  bqc_result_if.source result_o
);

  localparam int STATE_W = bqc_pkg::STATE_W;
  localparam int HALF_W  = STATE_W / 2;
  localparam int COEF_W  = bqc_pkg::COEF_W;
  localparam int PART_W  = HALF_W + COEF_W;
  localparam int PROD_W  = STATE_W + COEF_W;
  localparam int ACC_W   = STATE_W + 2;
  localparam int OUT_W   = bqc_pkg::OUT_W;

  localparam int OUT_SHR = (bqc_pkg::STATE_FRAC_BITS >= bqc_pkg::OUT_FRAC_BITS) ?
                           bqc_pkg::STATE_FRAC_BITS - bqc_pkg::OUT_FRAC_BITS : 0;
  localparam int OUT_SHL = (bqc_pkg::STATE_FRAC_BITS < bqc_pkg::OUT_FRAC_BITS) ?
                           bqc_pkg::OUT_FRAC_BITS - bqc_pkg::STATE_FRAC_BITS : 0;

  localparam logic [PROD_W-1:0] PROD_ROUND =
    PROD_W'((longint'(1) <<< bqc_pkg::COEF_FRAC_BITS) >>> 1);
  localparam logic [PROD_W-1:0] LIM_POS = PROD_W'((longint'(1) <<< (STATE_W - 1)) - 1);
  localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(longint'(1) <<< (STATE_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((longint'(1) <<< (STATE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(longint'(1) <<< (STATE_W - 1));
  localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'((longint'(1) <<< OUT_SHR) >>> 1);
  localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'((longint'(1) <<< (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_LO = -ACC_W'(longint'(1) <<< (OUT_W - 1));

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OPR  = 3'd1;
  localparam logic [2:0] ST_MLO  = 3'd2;
  localparam logic [2:0] ST_MHI  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_CONV = 3'd5;

  // Product positions within one section
  localparam logic [2:0] POS_B0 = 3'd0;
  localparam logic [2:0] POS_B1 = 3'd1;
  localparam logic [2:0] POS_A1 = 3'd2;
  localparam logic [2:0] POS_B2 = 3'd3;
  localparam logic [2:0] POS_A2 = 3'd4;

  logic [2:0]               state_q, state_d;
  logic                     sec_q, sec_d;
  logic [2:0]               pos_q, pos_d;
  bqc_pkg::state_t          x_q, x_d;
  bqc_pkg::state_t          y_q, y_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [STATE_W-1:0]       mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [PART_W-1:0]        plo_q, plo_d;
  logic [PROD_W-1:0]        psum_q, psum_d;
  bqc_pkg::state_t          dly_one_q [bqc_pkg::NUM_SEC];
  bqc_pkg::state_t          dly_two_q [bqc_pkg::NUM_SEC];
  bqc_pkg::state_t          dly_one_d, dly_two_d;
  logic                     out_valid_q, out_valid_d;
  bqc_pkg::result_t         out_data_q, out_data_d;

  logic [COEF_W-1:0]        coef_mag;
  logic [HALF_W-1:0]        mul_a;
  logic [PART_W-1:0]        mul_p;
  logic                     is_a_op;
  bqc_pkg::state_t          opnd;
  logic [PROD_W-1:0]        rmag_full;
  logic [PROD_W-1:0]        rlim;
  logic [STATE_W-1:0]       rsat;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  mag_ext;
  logic signed [ACC_W-1:0]  sum;
  bqc_pkg::state_t          sum_sat;
  logic signed [ACC_W-1:0]  conv_ext;
  logic signed [ACC_W-1:0]  conv_adj;
  logic signed [ACC_W-1:0]  conv_val;
  logic                     out_free;

  function automatic bqc_pkg::state_t sat_state(logic signed [ACC_W-1:0] v);
    bqc_pkg::state_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[STATE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[STATE_W-1:0];
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  assign coef_mag = bqc_pkg::COEF_MAG[sec_q][pos_q];
  assign is_a_op  = (pos_q == POS_A1) || (pos_q == POS_A2);
  assign opnd     = is_a_op ? y_q : x_q;

  // Shared multiplier: low half of the magnitude, then the high half
  assign mul_a = (state_q == ST_MHI) ? mag_q[STATE_W-1:HALF_W] : mag_q[HALF_W-1:0];
  assign mul_p = PART_W'(mul_a) * PART_W'(coef_mag);

  // Rounded product magnitude, clipped to the 48-bit range of its sign
  assign rmag_full = psum_q >> bqc_pkg::COEF_FRAC_BITS;
  assign rlim      = neg_q ? LIM_NEG : LIM_POS;
  assign rsat      = (rmag_full > rlim) ? rlim[STATE_W-1:0] : rmag_full[STATE_W-1:0];
  assign mag_ext   = ACC_W'({2'b00, rsat});

  always_comb begin
    case (pos_q)
      POS_B0:  base = ACC_W'(dly_one_q[sec_q]);
      POS_B1:  base = ACC_W'(dly_two_q[sec_q]);
      POS_B2:  base = '0;
      default: base = acc_q;
    endcase
  end

  // Subtract when the signed product, after the a-term negation, is negative
  assign sum     = (neg_q ^ is_a_op) ? base - mag_ext : base + mag_ext;
  assign sum_sat = sat_state(sum);

  // Output rescale: round half away from zero on a right shift, exact on a left shift
  assign conv_ext = ACC_W'(y_q);
  assign conv_adj = ACC_W'({1'b0, (y_q[STATE_W-1] && (OUT_SHR != 0))});
  assign conv_val = ((conv_ext + OUT_HALF - conv_adj) >>> OUT_SHR) <<< OUT_SHL;

  assign out_free = !out_valid_q || result_o.ready;

  always_comb begin
    state_d     = state_q;
    sec_d       = sec_q;
    pos_d       = pos_q;
    x_d         = x_q;
    y_d         = y_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    plo_d       = plo_q;
    psum_d      = psum_q;
    dly_one_d   = dly_one_q[sec_q];
    dly_two_d   = dly_two_q[sec_q];
    out_valid_d = out_valid_q && !result_o.ready;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          x_d     = STATE_W'(sample_i.sample_in) <<< bqc_pkg::STATE_FRAC_BITS;
          sec_d   = 1'b0;
          pos_d   = POS_B0;
          state_d = ST_OPR;
        end
      end
      ST_OPR: begin
        mag_d   = opnd[STATE_W-1] ? STATE_W'(-opnd) : STATE_W'(opnd);
        neg_d   = opnd[STATE_W-1] ^ bqc_pkg::COEF_NEG[sec_q][pos_q];
        state_d = ST_MLO;
      end
      ST_MLO: begin
        plo_d   = mul_p;
        state_d = ST_MHI;
      end
      ST_MHI: begin
        psum_d  = PROD_W'({mul_p, {HALF_W{1'b0}}}) + PROD_W'(plo_q) + PROD_ROUND;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        case (pos_q)
          POS_B0:  y_d       = sum_sat;
          POS_A1:  dly_one_d = sum_sat;
          POS_A2:  dly_two_d = sum_sat;
          default: acc_d     = sum;
        endcase
        state_d = ST_OPR;
        if (pos_q == POS_A2) begin
          pos_d = POS_B0;
          if (sec_q) begin
            state_d = ST_CONV;
          end else begin
            // section output feeds the next section
            x_d   = y_q;
            sec_d = 1'b1;
          end
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
      ST_CONV: begin
        // hold until the output register frees
        if (out_free) begin
          if (conv_val > OUT_HI) begin
            out_data_d = OUT_HI[OUT_W-1:0];
          end else if (conv_val < OUT_LO) begin
            out_data_d = OUT_LO[OUT_W-1:0];
          end else begin
            out_data_d = conv_val[OUT_W-1:0];
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= 1'b0;
      pos_q       <= POS_B0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < bqc_pkg::NUM_SEC; i++) begin
        dly_one_q[i] <= '0;
        dly_two_q[i] <= '0;
      end
    end else begin
      state_q            <= state_d;
      sec_q              <= sec_d;
      pos_q              <= pos_d;
      out_valid_q        <= out_valid_d;
      dly_one_q[sec_q]   <= dly_one_d;
      dly_two_q[sec_q]   <= dly_two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    acc_q      <= acc_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    plo_q      <= plo_d;
    psum_q     <= psum_d;
    out_data_q <= out_data_d;
  end

  assign sample_i.ready        = (state_q == ST_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.filtered_out = out_data_q;

endmodule

>>> sv/bqc_checker.sv
// Port-level checks of the biquad cascade, bound to the top level.
// Depends on bqc_pkg and biquad_cascade_bandpass.
module bqc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input bqc_pkg::result_t out_data_i
);

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed or dropped");

  // After an accepted item the block stays busy while it computes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i ##1 !in_ready_i)
    else $error("input ready while an item is in work");

  // A new result appears just as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result raised while the sequencer is busy");

  // No result can appear in the cycle right after an item is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i) |=> !out_valid_i)
    else $error("result appeared without computation");

endmodule

bind biquad_cascade_bandpass bqc_checker u_bqc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.filtered_out)
);

>>> verif/biquad_cascade_bandpass_tb.sv
// Self-checking testbench of the band-pass biquad cascade (low-pass then high-pass section).
// Depends on bqc_pkg, bqc_sample_if, bqc_result_if and biquad_cascade_bandpass; a bit-exact
// fixed-point predictor checks every filtered sample under random idling on both channels.
module biquad_cascade_bandpass_tb;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    bqc_pkg::sample_t value;
    bit               drain_first;
  } feed_t;

  typedef enum int {SEG_NOISE, SEG_LOW_NOISE, SEG_SQUARE, SEG_TRIANGLE, SEG_DC} segment_e;

  // Coefficient positions within one section
  localparam int B0 = 0;
  localparam int B1 = 1;
  localparam int B2 = 2;
  localparam int A1 = 3;
  localparam int A2 = 4;

  localparam int    ITEM_TARGET    = 1150;
  localparam int    QUIET_TAIL     = 100;
  localparam int    LONG_HOLD      = 400;
  localparam int    WATCHDOG_LIMIT = 3000;
  localparam int    SETTLE_CYCLES  = 60;
  localparam wide_t MAX48 = (wide_t'(1) <<< (bqc_pkg::STATE_W - 1)) - 1;
  localparam wide_t MIN48 = -MAX48 - 1;
  localparam wide_t MAX32 = (wide_t'(1) <<< (bqc_pkg::OUT_W - 1)) - 1;
  localparam wide_t MIN32 = -MAX32 - 1;

  logic clk_i;
  logic rst_ni;

  bqc_sample_if sample_ch ();
  bqc_result_if result_ch ();

  biquad_cascade_bandpass i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  wide_t            coef_q [bqc_pkg::NUM_SEC][bqc_pkg::NUM_POS];
  bqc_pkg::state_t  delay_line [bqc_pkg::NUM_SEC][2];
  feed_t            sample_feed [$];
  bqc_pkg::result_t expected_out [$];
  int               hold_marks [$];

  int      n_samples;
  int      n_results;
  int      n_errors;
  int      quiet_from;
  logic    sample_taken;
  int      idle_cycles;

  int               tx_gap;
  bit               offer;
  feed_t            cur;
  int               rx_hold;
  int               rx_gap;
  bit               take;
  bqc_pkg::result_t want;

  // Round to nearest, ties away from zero
  function automatic wide_t round_away(wide_t v, int sh);
    wide_t mag;
    if (sh <= 0) begin
      return v;
    end
    mag = (v < 0) ? -v : v;
    mag = (mag + (wide_t'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic wide_t clamp48(wide_t v);
    if (v > MAX48) return MAX48;
    if (v < MIN48) return MIN48;
    return v;
  endfunction

  // Coefficient product: magnitude rounded half up, then signed and saturated to 48 bits
  function automatic wide_t scaled_product(wide_t a, wide_t c);
    logic  neg;
    wide_t ua;
    wide_t uc;
    wide_t r;
    wide_t lim;
    neg = (a < 0) != (c < 0);
    ua  = (a < 0) ? -a : a;
    uc  = (c < 0) ? -c : c;
    r   = (ua * uc + (wide_t'(1) <<< (bqc_pkg::COEF_FRAC_BITS - 1)))
          >>> bqc_pkg::COEF_FRAC_BITS;
    lim = neg ? MAX48 + 1 : MAX48;
    if (r > lim) r = lim;
    return neg ? -r : r;
  endfunction

  function automatic wide_t biquad_section(int sec, wide_t x);
    wide_t y;
    wide_t z1;
    wide_t z2;
    y  = clamp48(scaled_product(x, coef_q[sec][B0]) + delay_line[sec][0]);
    z1 = clamp48(scaled_product(x, coef_q[sec][B1]) - scaled_product(y, coef_q[sec][A1])
                 + delay_line[sec][1]);
    z2 = clamp48(scaled_product(x, coef_q[sec][B2]) - scaled_product(y, coef_q[sec][A2]));
    delay_line[sec][0] = z1[bqc_pkg::STATE_W-1:0];
    delay_line[sec][1] = z2[bqc_pkg::STATE_W-1:0];
    return y;
  endfunction

  function automatic bqc_pkg::result_t bandpass_step(bqc_pkg::sample_t s);
    wide_t v;
    v = wide_t'(s) <<< bqc_pkg::STATE_FRAC_BITS;
    v = biquad_section(0, v);
    v = biquad_section(1, v);
    if (bqc_pkg::STATE_FRAC_BITS >= bqc_pkg::OUT_FRAC_BITS) begin
      v = round_away(v, bqc_pkg::STATE_FRAC_BITS - bqc_pkg::OUT_FRAC_BITS);
    end else begin
      v = v <<< (bqc_pkg::OUT_FRAC_BITS - bqc_pkg::STATE_FRAC_BITS);
    end
    if (v > MAX32) v = MAX32;
    if (v < MIN32) v = MIN32;
    return v[bqc_pkg::OUT_W-1:0];
  endfunction

  function automatic bit idling_allowed();
    return n_samples < quiet_from && (n_samples / 64) % 3 != 2;
  endfunction

  task automatic queue_sample(bqc_pkg::sample_t v);
    feed_t f;
    f.value       = v;
    f.drain_first = 1'b0;
    sample_feed.insert(sample_feed.size(), f);
  endtask

  // Sender: hold an offered item until taken, then pick the next one
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
    end else if (sample_taken || !sample_ch.valid) begin
      offer = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 2);
      end else if (sample_feed.size() != 0 &&
                   !(sample_feed[0].drain_first && expected_out.size() != 0)) begin
        cur   = sample_feed.pop_front();
        offer = 1'b1;
      end
      sample_ch.valid     <= offer;
      sample_ch.sample_in <= offer ? cur.value : bqc_pkg::sample_t'($urandom);
    end
  end

  // Receiver: random short stalls plus a few long holds to back up the pipeline
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      take = 1'b1;
      if (rx_hold > 0) begin
        rx_hold--;
        take = 1'b0;
      end else if (hold_marks.size() != 0 && n_results >= hold_marks[0]) begin
        void'(hold_marks.pop_front());
        rx_hold = LONG_HOLD - 1;
        take    = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        take = 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 2);
        take   = 1'b0;
      end
      result_ch.ready <= take;
    end
  end

  // Monitor: check results against the oldest expectation, predict each accepted sample
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        n_results++;
        if (expected_out.size() == 0) begin
          $error("filtered_out: no item expected, got %0d", result_ch.filtered_out);
          n_errors++;
        end else begin
          want = expected_out.pop_front();
          if (result_ch.filtered_out !== want) begin
            $error("filtered_out: expected %0d, got %0d", want, result_ch.filtered_out);
            n_errors++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        n_samples++;
        expected_out.insert(expected_out.size(), bandpass_step(sample_ch.sample_in));
      end
    end
    sample_taken <= rst_ni && sample_ch.valid && sample_ch.ready;
  end

  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[biquad_cascade_bandpass] ERROR");
      $finish;
    end
  end

  initial begin
    segment_e         kind;
    int               len;
    int               half;
    int               amp;
    int               step;
    int               lvl;
    int               dir;
    int               n_directed;
    bqc_pkg::sample_t v;

    rst_ni              = 1'b0;
    sample_ch.valid     = 1'b0;
    sample_ch.sample_in = '0;
    result_ch.ready     = 1'b0;
    sample_taken        = 1'b0;
    n_samples           = 0;
    n_results           = 0;
    n_errors            = 0;
    idle_cycles         = 0;
    tx_gap              = 0;
    rx_hold             = 0;
    rx_gap              = 0;
    hold_marks          = '{200, 650};

    for (int s = 0; s < bqc_pkg::NUM_SEC; s++) begin
      for (int k = 0; k < bqc_pkg::NUM_POS; k++) begin
        coef_q[s][k] = round_away(wide_t'(bqc_pkg::COEF_Q30[s][k]),
                                  30 - bqc_pkg::COEF_FRAC_BITS);
      end
      delay_line[s][0] = '0;
      delay_line[s][1] = '0;
    end

    // Directed: extremes, impulse, full-scale step, Nyquist-rate square, bit patterns
    queue_sample(16'sd0);
    queue_sample(16'sd32767);
    queue_sample(-16'sd32768);
    queue_sample(16'sd1);
    queue_sample(-16'sd1);
    queue_sample(16'sd32767);
    repeat (3) queue_sample(16'sd0);
    repeat (4) queue_sample(16'sd32767);
    for (int i = 0; i < 6; i++) begin
      queue_sample(i % 2 ? -16'sd32768 : 16'sd32767);
    end
    queue_sample(16'h5555);
    queue_sample(16'hAAAA);
    queue_sample(-16'sd32768);
    queue_sample(-16'sd32768);
    n_directed = sample_feed.size();

    while (sample_feed.size() < ITEM_TARGET) begin
      kind = segment_e'($urandom_range(0, 4));
      len  = $urandom_range(16, 80);
      case (kind)
        SEG_NOISE: begin
          repeat (len) queue_sample(bqc_pkg::sample_t'($urandom));
        end
        SEG_LOW_NOISE: begin
          repeat (len) queue_sample(bqc_pkg::sample_t'(int'($urandom_range(0, 511)) - 256));
        end
        SEG_SQUARE: begin
          half = $urandom_range(1, 40);
          for (int i = 0; i < len; i++) begin
            queue_sample(((i / half) % 2) ? -16'sd32768 : 16'sd32767);
          end
        end
        SEG_TRIANGLE: begin
          amp  = $urandom_range(1, 32767);
          step = $urandom_range(1, 4096);
          lvl  = 0;
          dir  = 1;
          repeat (len) begin
            lvl = lvl + dir * step;
            if (lvl > amp) begin
              lvl = amp;
              dir = -1;
            end else if (lvl < -amp) begin
              lvl = -amp;
              dir = 1;
            end
            queue_sample(bqc_pkg::sample_t'(lvl));
          end
        end
        default: begin
          v = bqc_pkg::sample_t'($urandom);
          repeat (len) queue_sample(v);
        end
      endcase
    end
    // Let the pipeline run dry before these items
    sample_feed[n_directed].drain_first = 1'b1;
    sample_feed[600].drain_first        = 1'b1;
    quiet_from = sample_feed.size() - QUIET_TAIL;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (sample_feed.size() != 0 || sample_ch.valid || expected_out.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("[biquad_cascade_bandpass] OK");
    end else begin
      $display("[biquad_cascade_bandpass] ERROR");
    end
    $finish;
  end

endmodule
